// ===== rtl/runtime_stopwatch_minmax_defines.svh =====
// Assertion macros for the run-time stopwatch checker.
`ifndef RUNTIME_STOPWATCH_MINMAX_DEFINES_SVH
`define RUNTIME_STOPWATCH_MINMAX_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define RSM_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("stopwatch check failed");

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define RSM_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("stopwatch check failed");

`endif

// ===== rtl/rsm_pkg.sv =====
// Shared constants, command codes and result word type for the run-time stopwatch.
package rsm_pkg;

	localparam int TIME_WIDTH = 32;
	localparam int OUT_W      = 32;
	localparam int CMD_W      = 3;

	typedef enum logic [CMD_W-1:0] {
		CMD_CLEAR  = 3'd0,
		CMD_START  = 3'd1,
		CMD_PAUSE  = 3'd2,
		CMD_RESUME = 3'd3,
		CMD_STOP   = 3'd4,
		CMD_DECAY  = 3'd5
	} cmd_t;

	typedef struct packed {
		logic [OUT_W-1:0] gross_time;
		logic [OUT_W-1:0] net_time;
		logic [OUT_W-1:0] running_total;
		logic [OUT_W-1:0] min_net;
		logic [OUT_W-1:0] max_net;
		logic [OUT_W-1:0] mid_net;
	} stats_t;

endpackage

// ===== rtl/rsm_state.sv =====
// Measurement state registers and the per-command update logic.
module rsm_state #(
	parameter int TIME_WIDTH = rsm_pkg::TIME_WIDTH
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       step,
	input  logic [rsm_pkg::CMD_W-1:0]  command,
	input  logic [rsm_pkg::OUT_W-1:0]  timestamp,
	output rsm_pkg::stats_t            stats_next
);

	localparam int TW = TIME_WIDTH;
	localparam int OW = rsm_pkg::OUT_W;
	localparam logic [TW-1:0] ONES = {TW{1'b1}};
	localparam logic [TW-1:0] ONE  = {{(TW-1){1'b0}}, 1'b1};

	logic [TW-1:0] start_q, last_q, acc_q, gross_q, net_q, min_q, max_q, mid_q;
	logic [TW-1:0] start_d, last_d, acc_d, gross_d, net_d, min_d, max_d, mid_d;

	logic [TW+OW-1:0] ts_wide;
	logic [TW-1:0]    now;
	logic [TW-1:0]    gap;
	logic [TW-1:0]    acc_sum;
	logic [TW-1:0]    max_stop, min_stop, mid_sum;

	function automatic logic [OW-1:0] to_out(input logic [TW-1:0] v);
		logic [TW+OW-1:0] w;
		w = {{OW{1'b0}}, v};
		return w[OW-1:0];
	endfunction

	assign ts_wide = {{TW{1'b0}}, timestamp};
	assign now     = ts_wide[TW-1:0];

	// absolute distance, no wrap correction
	assign gap      = (now > last_q) ? (now - last_q) : (last_q - now);
	assign acc_sum  = acc_q + gap;
	assign max_stop = (max_q < acc_sum) ? acc_sum : max_q;
	assign min_stop = (min_q > acc_sum) ? acc_sum : min_q;
	assign mid_sum  = max_stop + min_stop;

	always_comb begin
		start_d = start_q;
		last_d  = last_q;
		acc_d   = acc_q;
		gross_d = gross_q;
		net_d   = net_q;
		min_d   = min_q;
		max_d   = max_q;
		mid_d   = mid_q;
		unique case (rsm_pkg::cmd_t'(command))
			rsm_pkg::CMD_CLEAR: begin
				acc_d = '0;
				min_d = ONES;
				max_d = '0;
				mid_d = '0;
			end
			rsm_pkg::CMD_START: begin
				start_d = now;
				last_d  = now;
				acc_d   = '0;
			end
			rsm_pkg::CMD_PAUSE: begin
				acc_d  = acc_sum;
				last_d = now;
			end
			rsm_pkg::CMD_RESUME: begin
				last_d = now;
			end
			rsm_pkg::CMD_STOP: begin
				acc_d   = acc_sum;
				last_d  = now;
				gross_d = now - start_q;
				net_d   = acc_sum;
				max_d   = max_stop;
				min_d   = min_stop;
				mid_d   = mid_sum >> 1;
			end
			rsm_pkg::CMD_DECAY: begin
				if (max_q > mid_q) max_d = max_q - ONE;
				if (min_q < mid_q) min_d = min_q + ONE;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= '0;
			last_q  <= '0;
			acc_q   <= '0;
			gross_q <= '0;
			net_q   <= '0;
			min_q   <= ONES;
			max_q   <= '0;
			mid_q   <= '0;
		end else if (step) begin
			start_q <= start_d;
			last_q  <= last_d;
			acc_q   <= acc_d;
			gross_q <= gross_d;
			net_q   <= net_d;
			min_q   <= min_d;
			max_q   <= max_d;
			mid_q   <= mid_d;
		end
	end

	// result word reports the state after the command has acted
	assign stats_next.gross_time    = to_out(gross_d);
	assign stats_next.net_time      = to_out(net_d);
	assign stats_next.running_total = to_out(acc_d);
	assign stats_next.min_net       = to_out(min_d);
	assign stats_next.max_net       = to_out(max_d);
	assign stats_next.mid_net       = to_out(mid_d);

endmodule

// ===== rtl/rsm_out_stage.sv =====
// Result register with valid/stall handshake towards the consumer.
module rsm_out_stage (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            load,
	input  rsm_pkg::stats_t stats_in,
	input  logic            hold,
	output logic            valid,
	output rsm_pkg::stats_t stats,
	output logic            free
);

	logic            valid_s2;
	rsm_pkg::stats_t stats_s2;

	// free when empty or the word is taken this cycle
	assign free = !valid_s2 || !hold;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (load) begin
			valid_s2 <= 1'b1;
		end else if (!hold) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			stats_s2 <= stats_in;
		end
	end

	assign valid = valid_s2;
	assign stats = stats_s2;

endmodule

// ===== rtl/runtime_stopwatch_minmax.sv =====
// Top level of the run-time stopwatch with net-time minimum and maximum tracking.
// One command word (clear, start, pause, resume, stop, decay plus a timestamp) is taken
// every cycle while cmd_stall is low; each produces one result word with all six statistics
// as they stand after the command. The command word is registered, the state update runs
// in one pass between that register and the result register, and the state registers move
// together with the result register. Back-pressure on the stat side stalls the command
// side only once both registers are full. Unused command codes leave the state alone and
// still return a result word.
module runtime_stopwatch_minmax #(
	parameter int TIME_WIDTH = rsm_pkg::TIME_WIDTH
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cmd_valid,
	output logic                      cmd_stall,
	input  logic [rsm_pkg::CMD_W-1:0] command,
	input  logic [rsm_pkg::OUT_W-1:0] timestamp,
	output logic                      stat_valid,
	input  logic                      stat_stall,
	output logic [rsm_pkg::OUT_W-1:0] gross_time,
	output logic [rsm_pkg::OUT_W-1:0] net_time,
	output logic [rsm_pkg::OUT_W-1:0] running_total,
	output logic [rsm_pkg::OUT_W-1:0] min_net,
	output logic [rsm_pkg::OUT_W-1:0] max_net,
	output logic [rsm_pkg::OUT_W-1:0] mid_net
);

	logic                      valid_s1;
	logic [rsm_pkg::CMD_W-1:0] cmd_s1;
	logic [rsm_pkg::OUT_W-1:0] ts_s1;
	logic                      s2_free;
	logic                      advance;
	logic                      take;
	rsm_pkg::stats_t           stats_next;
	rsm_pkg::stats_t           stats_out;

	assign advance   = valid_s1 && s2_free;
	assign cmd_stall = valid_s1 && !s2_free;
	assign take      = cmd_valid && !cmd_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			cmd_s1 <= command;
			ts_s1  <= timestamp;
		end
	end

	rsm_state #(
		.TIME_WIDTH(TIME_WIDTH)
	) u_state (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (advance),
		.command   (cmd_s1),
		.timestamp (ts_s1),
		.stats_next(stats_next)
	);

	rsm_out_stage u_out (
		.clk     (clk),
		.arst_n  (arst_n),
		.load    (advance),
		.stats_in(stats_next),
		.hold    (stat_stall),
		.valid   (stat_valid),
		.stats   (stats_out),
		.free    (s2_free)
	);

	assign gross_time    = stats_out.gross_time;
	assign net_time      = stats_out.net_time;
	assign running_total = stats_out.running_total;
	assign min_net       = stats_out.min_net;
	assign max_net       = stats_out.max_net;
	assign mid_net       = stats_out.mid_net;

endmodule

// ===== rtl/rsm_checker.sv =====
// Port-level checks for the run-time stopwatch, bound to the top level.
`include "runtime_stopwatch_minmax_defines.svh"

module rsm_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      cmd_valid,
	input logic                      cmd_stall,
	input logic [rsm_pkg::CMD_W-1:0] command,
	input logic [rsm_pkg::OUT_W-1:0] timestamp,
	input logic                      stat_valid,
	input logic                      stat_stall,
	input logic [rsm_pkg::OUT_W-1:0] gross_time,
	input logic [rsm_pkg::OUT_W-1:0] net_time,
	input logic [rsm_pkg::OUT_W-1:0] running_total,
	input logic [rsm_pkg::OUT_W-1:0] min_net,
	input logic [rsm_pkg::OUT_W-1:0] max_net,
	input logic [rsm_pkg::OUT_W-1:0] mid_net
);

	logic                        stat_held;
	logic [6*rsm_pkg::OUT_W-1:0] stat_word;

	assign stat_held = stat_valid && stat_stall;
	assign stat_word = {gross_time, net_time, running_total, min_net, max_net, mid_net};

	// a stalled result word stays offered
	`RSM_ASSERT_NEXT(a_stat_valid_hold, stat_held, stat_valid)

	// and its contents stay put
	`RSM_ASSERT_NEXT(a_stat_word_hold, stat_held, $stable(stat_word))

	// commands back up only when both stages are full behind a stalled result
	`RSM_ASSERT_NOW(a_stall_cause, cmd_stall, stat_valid && stat_stall)

	// a fresh result word must trace back to an accepted command
	`RSM_ASSERT_NOW(a_result_source, $rose(stat_valid), $past(cmd_valid && !cmd_stall, 2))

endmodule

bind runtime_stopwatch_minmax rsm_checker u_rsm_checker (.*);

// ===== verif/rsm_checker.sv =====
// Checker for the run-time stopwatch: predicts each result word and compares it.
`timescale 1ns / 100ps

module rsm_tb_checker
	import rsm_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cmd_valid,
	input  logic             cmd_stall,
	input  logic [CMD_W-1:0] command,
	input  logic [OUT_W-1:0] timestamp,
	input  logic             stat_valid,
	input  logic             stat_stall,
	input  logic [OUT_W-1:0] gross_time,
	input  logic [OUT_W-1:0] net_time,
	input  logic [OUT_W-1:0] running_total,
	input  logic [OUT_W-1:0] min_net,
	input  logic [OUT_W-1:0] max_net,
	input  logic [OUT_W-1:0] mid_net,
	output int               fail_count,
	output int               due_count,
	output int               word_count
);

	// Predicted stopwatch state
	logic [OUT_W-1:0] begin_ts;
	logic [OUT_W-1:0] mark_ts;
	logic [OUT_W-1:0] run_acc;
	logic [OUT_W-1:0] gross_q;
	logic [OUT_W-1:0] net_q;
	logic [OUT_W-1:0] lo_q;
	logic [OUT_W-1:0] hi_q;
	logic [OUT_W-1:0] centre_q;

	stats_t stats_due[$];

	// Absolute distance, no wrap correction; the sum itself wraps
	function automatic void accrue(input logic [OUT_W-1:0] now);
		if (now > mark_ts)
			run_acc = run_acc + (now - mark_ts);
		else
			run_acc = run_acc + (mark_ts - now);
		mark_ts = now;
	endfunction

	function automatic stats_t advance_stopwatch(input logic [CMD_W-1:0] op,
			input logic [OUT_W-1:0] now);
		stats_t s;
		logic [OUT_W-1:0] sum;
		case (op)
			CMD_CLEAR: begin
				run_acc  = '0;
				lo_q     = '1;
				hi_q     = '0;
				centre_q = '0;
			end
			CMD_START: begin
				begin_ts = now;
				mark_ts  = now;
				run_acc  = '0;
			end
			CMD_PAUSE:  accrue(now);
			CMD_RESUME: mark_ts = now;
			CMD_STOP: begin
				accrue(now);
				gross_q = mark_ts - begin_ts;
				net_q   = run_acc;
				if (hi_q < net_q)
					hi_q = net_q;
				if (lo_q > net_q)
					lo_q = net_q;
				sum      = hi_q + lo_q;
				centre_q = sum >> 1;
			end
			CMD_DECAY: begin
				if (hi_q > centre_q)
					hi_q = hi_q - OUT_W'(1);
				if (lo_q < centre_q)
					lo_q = lo_q + OUT_W'(1);
			end
			default: ;
		endcase
		s.gross_time    = gross_q;
		s.net_time      = net_q;
		s.running_total = run_acc;
		s.min_net       = lo_q;
		s.max_net       = hi_q;
		s.mid_net       = centre_q;
		return s;
	endfunction

	function automatic void check_field(input string name, input logic [OUT_W-1:0] exp_v,
			input logic [OUT_W-1:0] act_v);
		if (act_v !== exp_v) begin
			$display("%0t: %s expected %h got %h", $time, name, exp_v, act_v);
			fail_count++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		stats_t due;
		if (!arst_n) begin
			begin_ts = '0;
			mark_ts  = '0;
			run_acc  = '0;
			gross_q  = '0;
			net_q    = '0;
			lo_q     = '1;
			hi_q     = '0;
			centre_q = '0;
			stats_due.delete();
			fail_count = 0;
			word_count = 0;
		end else begin
			if (stat_valid && !stat_stall) begin
				word_count++;
				if (stats_due.size() == 0) begin
					$display("%0t: result word with nothing expected", $time);
					fail_count++;
				end else begin
					due = stats_due.pop_front();
					check_field("gross_time", due.gross_time, gross_time);
					check_field("net_time", due.net_time, net_time);
					check_field("running_total", due.running_total, running_total);
					check_field("min_net", due.min_net, min_net);
					check_field("max_net", due.max_net, max_net);
					check_field("mid_net", due.mid_net, mid_net);
				end
			end
			if (cmd_valid && !cmd_stall)
				stats_due.push_back(advance_stopwatch(command, timestamp));
		end
		due_count = stats_due.size();
	end

endmodule

// ===== verif/tb_runtime_stopwatch_minmax.sv =====
// Testbench top for the run-time stopwatch: command stimulus, back-pressure and verdict.
`timescale 1ns / 100ps

module tb_runtime_stopwatch_minmax;
	import rsm_pkg::*;

	localparam int               N_WORDS       = 1750;
	localparam int               QUIET_LIMIT   = 2000;
	localparam logic [CMD_W-1:0] CMD_UNUSED_LO = 3'd6;
	localparam logic [CMD_W-1:0] CMD_UNUSED_HI = 3'd7;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             cmd_valid = 1'b0;
	logic             cmd_stall;
	logic [CMD_W-1:0] command = '0;
	logic [OUT_W-1:0] timestamp = '0;
	logic             stat_valid;
	logic             stat_stall = 1'b0;
	logic [OUT_W-1:0] gross_time;
	logic [OUT_W-1:0] net_time;
	logic [OUT_W-1:0] running_total;
	logic [OUT_W-1:0] min_net;
	logic [OUT_W-1:0] max_net;
	logic [OUT_W-1:0] mid_net;

	int fail_count;
	int due_count;
	int word_count;
	int n_sent = 0;
	int cmd_seen[8];
	int quiet_cycles = 0;
	bit calm = 1'b0;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	runtime_stopwatch_minmax u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd_valid     (cmd_valid),
		.cmd_stall     (cmd_stall),
		.command       (command),
		.timestamp     (timestamp),
		.stat_valid    (stat_valid),
		.stat_stall    (stat_stall),
		.gross_time    (gross_time),
		.net_time      (net_time),
		.running_total (running_total),
		.min_net       (min_net),
		.max_net       (max_net),
		.mid_net       (mid_net)
	);

	rsm_tb_checker u_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd_valid     (cmd_valid),
		.cmd_stall     (cmd_stall),
		.command       (command),
		.timestamp     (timestamp),
		.stat_valid    (stat_valid),
		.stat_stall    (stat_stall),
		.gross_time    (gross_time),
		.net_time      (net_time),
		.running_total (running_total),
		.min_net       (min_net),
		.max_net       (max_net),
		.mid_net       (mid_net),
		.fail_count    (fail_count),
		.due_count     (due_count),
		.word_count    (word_count)
	);

	always @(negedge clk) begin
		if (calm)
			stat_stall <= 1'b0;
		else
			stat_stall <= ($urandom_range(0, 99) < 29);
	end

	// Watchdog: consecutive cycles with no word moving on either side
	always @(posedge clk) begin
		if (arst_n) begin
			if ((cmd_valid && !cmd_stall) || (stat_valid && !stat_stall)) begin
				quiet_cycles <= 0;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
				if (quiet_cycles >= QUIET_LIMIT) begin
					$display("%0t: no word moved for %0d cycles, %0d results outstanding",
						$time, QUIET_LIMIT, due_count);
					$display("CHECKS FAILED");
					$finish;
				end
			end
		end
	end

	// Called at a falling edge; returns at the falling edge after acceptance
	task automatic send_word(input logic [CMD_W-1:0] c, input logic [OUT_W-1:0] t);
		while (!calm && $urandom_range(0, 99) < 29) begin
			cmd_valid <= 1'b0;
			@(negedge clk);
		end
		cmd_valid <= 1'b1;
		command   <= c;
		timestamp <= t;
		@(posedge clk);
		while (cmd_stall)
			@(posedge clk);
		@(negedge clk);
		cmd_seen[c]++;
		n_sent++;
	endtask

	// Spread of magnitudes so that short and long intervals both occur
	function automatic logic [OUT_W-1:0] time_step();
		logic [OUT_W-1:0] mask;
		mask = 32'hFFFF_FFFF >> $urandom_range(0, 31);
		return $urandom & mask;
	endfunction

	// One measurement: an optional clear, start, zero to three pause/resume pairs, stop, zero to three decays
	task automatic run_measurement();
		logic [OUT_W-1:0] t;
		int pairs;
		int decays;
		if ($urandom_range(0, 7) == 0)
			send_word(CMD_CLEAR, $urandom);
		t = $urandom;
		send_word(CMD_START, t);
		pairs = $urandom_range(0, 3);
		repeat (pairs) begin
			t = t + time_step();
			send_word(CMD_PAUSE, t);
			t = t + time_step();
			send_word(CMD_RESUME, t);
		end
		t = t + time_step();
		send_word(CMD_STOP, t);
		decays = $urandom_range(0, 3);
		repeat (decays)
			send_word(CMD_DECAY, $urandom);
	endtask

	initial begin
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed: untouched state, pause/resume/stop with no start, wrap-around
		send_word(CMD_DECAY, 32'h0);
		send_word(CMD_PAUSE, 32'hFFFF_FFFF);
		send_word(CMD_PAUSE, 32'h0);
		send_word(CMD_RESUME, 32'h1234_5678);
		send_word(CMD_STOP, 32'h0000_0001);
		send_word(CMD_CLEAR, 32'hFFFF_FFFF);
		send_word(CMD_START, 32'hFFFF_FFF0);
		send_word(CMD_PAUSE, 32'hFFFF_FFFF);
		send_word(CMD_RESUME, 32'h0000_0005);
		send_word(CMD_STOP, 32'h0000_0010);
		send_word(CMD_START, 32'd100);
		send_word(CMD_STOP, 32'd100);
		// full-scale net after clear: min + max wraps
		send_word(CMD_CLEAR, 32'h0);
		send_word(CMD_START, 32'h0);
		send_word(CMD_STOP, 32'hFFFF_FFFF);
		send_word(CMD_DECAY, 32'hAAAA_AAAA);
		send_word(CMD_DECAY, 32'h5555_5555);
		send_word(CMD_UNUSED_LO, 32'hFFFF_FFFF);
		send_word(CMD_UNUSED_HI, 32'h0);
		// timestamp running backwards
		send_word(CMD_START, 32'd1000);
		send_word(CMD_PAUSE, 32'd500);
		send_word(CMD_RESUME, 32'd400);
		send_word(CMD_STOP, 32'd300);
		send_word(CMD_CLEAR, 32'h0);
		send_word(CMD_DECAY, 32'h0);

		while (n_sent < N_WORDS) begin
			calm = (n_sent >= 700 && n_sent < 1000);
			if ($urandom_range(0, 99) < 75)
				run_measurement();
			else
				send_word(CMD_W'($urandom_range(0, 7)), $urandom);
		end
		calm = 1'b0;
		cmd_valid <= 1'b0;

		while (due_count != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);

		$display("%0d command words: clear %0d, start %0d, pause %0d, resume %0d, stop %0d,",
			n_sent, cmd_seen[CMD_CLEAR], cmd_seen[CMD_START], cmd_seen[CMD_PAUSE],
			cmd_seen[CMD_RESUME], cmd_seen[CMD_STOP]);
		$display("decay %0d, unused codes %0d; %0d result words compared, %0d mismatches",
			cmd_seen[CMD_DECAY], cmd_seen[CMD_UNUSED_LO] + cmd_seen[CMD_UNUSED_HI],
			word_count, fail_count);
		if (fail_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
